// ----- sv/aa2d_pkg.sv -----
// shared types and constants of the 2d area allocator
// no dependencies; used by the top level and the checker
package aa2d_pkg;

    localparam int ROW_SLOTS_DEF = 256;
    localparam int ROWS_DEF      = 128;
    localparam int POS_W         = 15;
    localparam int MODE_W        = 2;
    localparam int WIDTH_W       = 9;
    localparam int HEIGHT_W      = 8;
    localparam int AMASK_W       = 8;
    localparam int OFFB_W        = 12;
    localparam int BAND_W        = 4;

    localparam logic [BAND_W-1:0] BAND_RESET = 4'd6;
    localparam logic [BAND_W-1:0] BAND_MAX   = 4'd8;

    localparam logic [MODE_W-1:0] MODE_RECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

endpackage

// ----- sv/aa2d_span_mask.sv -----
// row mask generator: sets the slots lo up to hi-1 of one bitmap row
// depends on nothing but its parameter
module aa2d_span_mask #(
    parameter int ROW_SLOTS = 256
) (
    input  logic [$clog2(ROW_SLOTS):0] lo,
    input  logic [$clog2(ROW_SLOTS):0] hi,
    output logic [ROW_SLOTS-1:0]       mask
);

    localparam int CW = $clog2(ROW_SLOTS) + 1;

    always_comb
    begin
        for (int k = 0; k < ROW_SLOTS; k++)
        begin
            mask[k] = (CW'(k) >= lo) && (CW'(k) < hi);
        end
    end

endmodule

// ----- sv/area_allocator_2d_bitmap.sv -----
// top level of the 2d bitmap area allocator: control sequencer and occupancy memory
// depends on aa2d_pkg and aa2d_span_mask
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid in_ready mode width height ...   | one request per transaction
//  out     | out_valid out_ready status found_position | one result per request
//  cfg     | cfg_valid cfg_ready band_slots_log2       | band size register write
//
// a 2d request, for each tried start row, reads and merges the rows of height and
//   then scans the columns; a 1d request walks down one slot at a time from the top
//   end, reading each bitmap row that it enters; marking or freeing reads and writes
//   each touched bitmap row for every row of height; an accept step and a result
//   step frame each request
// after reset a clearing pass zeroes the bitmap, one row at a time, with in_ready low
// one request at a time; in_ready is high only when idle with no result waiting,
//   so a stalled result holds off the next request
// ROW_SLOTS must be a power of two
module area_allocator_2d_bitmap #(
    parameter int ROW_SLOTS = aa2d_pkg::ROW_SLOTS_DEF,
    parameter int ROWS      = aa2d_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [aa2d_pkg::MODE_W-1:0]   mode,
    input  logic [aa2d_pkg::WIDTH_W-1:0]  width,
    input  logic [aa2d_pkg::HEIGHT_W-1:0] height,
    input  logic [aa2d_pkg::AMASK_W-1:0]  align_mask,
    input  logic [aa2d_pkg::OFFB_W-1:0]   offset_bytes,
    input  logic [aa2d_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [aa2d_pkg::POS_W-1:0]    found_position,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aa2d_pkg::BAND_W-1:0]   band_slots_log2
);

    localparam int COL_W = $clog2(ROW_SLOTS);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW    = ROW_W + COL_W;
    // wide enough for a free range start plus height rows and width
    localparam int EW    = ((LW > aa2d_pkg::POS_W) ? LW : aa2d_pkg::POS_W) + 2;
    localparam int MW    = COL_W + 1;
    localparam logic [EW-1:0] TOTAL = EW'(ROWS) << COL_W;

    typedef enum logic [10:0] {
        S_CLR     = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_ACC_RD  = 11'b00000000100,
        S_ACC     = 11'b00000001000,
        S_SCAN    = 11'b00000010000,
        S_RUN_RD  = 11'b00000100000,
        S_RUN     = 11'b00001000000,
        S_MK_INIT = 11'b00010000000,
        S_MK_RD   = 11'b00100000000,
        S_MK_WR   = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // request registers
    logic [aa2d_pkg::WIDTH_W-1:0]  w_reg, w_next;
    logic [aa2d_pkg::HEIGHT_W-1:0] h_reg, h_next;
    logic [aa2d_pkg::AMASK_W-1:0]  amask_reg, amask_next;
    logic [aa2d_pkg::OFFB_W-1:0]   offb_reg, offb_next;
    logic [aa2d_pkg::BAND_W-1:0]   band_reg;

    // search and marking state
    logic [ROW_W:0]          r_reg, r_next;
    logic [8:0]              i_reg, i_next;
    logic [ROW_SLOTS-1:0]    acc_reg, acc_next;
    logic [COL_W-1:0]        c_reg, c_next;
    logic [LW-1:0]           p_reg, p_next;
    logic [9:0]              run_reg, run_next;
    logic [EW-1:0]           base_reg, base_next;
    logic [EW-1:0]           cr_reg, cr_next;
    logic                    set_reg, set_next;
    logic [ROW_W:0]          clr_reg, clr_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          status_reg, status_next;
    logic [aa2d_pkg::POS_W-1:0]    found_reg, found_next;

    // occupancy memory, one row per entry
    logic [ROW_SLOTS-1:0] occ_mem [ROWS];
    logic [ROW_SLOTS-1:0] rdata_reg;
    logic                 mem_we, mem_re;
    logic [ROW_W-1:0]     mem_addr;
    logic [ROW_SLOTS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= occ_mem[mem_addr];
        end
    end

    // column acceptance for a 2d start: offset match or alignment
    logic [aa2d_pkg::BAND_W-1:0] lg;
    logic [15:0] band_mask, want, c_ext;
    logic        col_ok;

    assign lg        = (band_reg > aa2d_pkg::BAND_MAX) ? aa2d_pkg::BAND_MAX : band_reg;
    assign band_mask = (16'd1 << lg) - 16'd1;
    assign want      = 16'(offb_reg) >> (4'd12 - lg);
    assign c_ext     = 16'(c_reg);
    assign col_ok    = (offb_reg != '0) ? ((c_ext & band_mask) == want)
                                        : ((c_ext & 16'(amask_reg)) == 16'd0);

    // rectangle fit at column c within the merged rows
    logic [15:0]          scan_end;
    logic                 scan_fits;
    logic [MW-1:0]        scan_lo, scan_hi;
    logic [ROW_SLOTS-1:0] scan_mask;
    logic                 scan_hit;

    assign scan_end  = c_ext + 16'(w_reg);
    assign scan_fits = scan_end <= 16'(ROW_SLOTS);
    assign scan_lo   = MW'(c_reg);
    assign scan_hi   = scan_fits ? MW'(scan_end) : MW'(ROW_SLOTS);
    assign scan_hit  = col_ok && scan_fits && ((acc_reg & scan_mask) == '0);

    aa2d_span_mask #(.ROW_SLOTS(ROW_SLOTS)) u_scan_mask (
        .lo   (scan_lo),
        .hi   (scan_hi),
        .mask (scan_mask)
    );

    // slots of the current linear range that fall in row cr
    logic [EW-1:0]        row_base, row_top, end_lin, end_m1;
    logic [MW-1:0]        mk_lo, mk_hi;
    logic [ROW_SLOTS-1:0] mk_mask;
    logic                 mk_last;

    assign row_base = cr_reg << COL_W;
    assign row_top  = row_base + EW'(ROW_SLOTS);
    assign end_lin  = base_reg + EW'(w_reg);
    assign end_m1   = end_lin - EW'(1);
    assign mk_lo    = (base_reg > row_base) ? MW'(base_reg - row_base) : '0;
    assign mk_hi    = (end_lin < row_top) ? MW'(end_lin - row_base) : MW'(ROW_SLOTS);
    assign mk_last  = ((end_m1 >> COL_W) == cr_reg) || (cr_reg + EW'(1) >= EW'(ROWS));

    aa2d_span_mask #(.ROW_SLOTS(ROW_SLOTS)) u_mark_mask (
        .lo   (mk_lo),
        .hi   (mk_hi),
        .mask (mk_mask)
    );

    // 1d walk helpers
    logic [COL_W-1:0] p_col;
    logic             p_used;
    logic [9:0]       run_inc;

    assign p_col   = p_reg[COL_W-1:0];
    assign p_used  = rdata_reg[p_col];
    assign run_inc = run_reg + 10'd1;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        amask_next     = amask_reg;
        offb_next      = offb_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        base_next      = base_reg;
        cr_next        = cr_reg;
        set_next       = set_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_fire;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = '0;

        unique case (state_reg)
            S_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = ROW_W'(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ROW_W+1)'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    w_next      = width;
                    h_next      = height;
                    amask_next  = align_mask;
                    offb_next   = offset_bytes;
                    status_next = 1'b1;
                    found_next  = '0;
                    i_next      = '0;
                    priority if (mode == aa2d_pkg::MODE_RECT)
                    begin
                        if (width == '0 || height == '0 || 32'(width) > ROW_SLOTS
                            || 32'(height) > ROWS)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            r_next     = '0;
                            acc_next   = '0;
                            state_next = S_ACC_RD;
                        end
                    end
                    else if (mode == aa2d_pkg::MODE_RUN)
                    begin
                        if (width == '0 || EW'(width) > TOTAL)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            p_next     = LW'(TOTAL - EW'(1));
                            run_next   = '0;
                            state_next = S_RUN_RD;
                        end
                    end
                    else if (mode == aa2d_pkg::MODE_FREE)
                    begin
                        status_next = 1'b0;
                        found_next  = position;
                        base_next   = EW'(position);
                        set_next    = 1'b0;
                        state_next  = S_MK_INIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ACC_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = ROW_W'(r_reg + (ROW_W+1)'(i_reg));
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg | rdata_reg;
                if (i_reg + 9'd1 == 9'(h_reg))
                begin
                    i_next     = '0;
                    c_next     = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_ACC_RD;
                end
            end
            S_SCAN:
            begin
                priority if (scan_hit)
                begin
                    status_next = 1'b0;
                    found_next  = aa2d_pkg::POS_W'((EW'(r_reg) << COL_W) | EW'(c_reg));
                    base_next   = (EW'(r_reg) << COL_W) | EW'(c_reg);
                    i_next      = '0;
                    set_next    = 1'b1;
                    state_next  = S_MK_INIT;
                end
                else if (c_reg == COL_W'(ROW_SLOTS - 1))
                begin
                    if (32'(r_reg) + 1 + 32'(h_reg) > ROWS)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        acc_next   = '0;
                        i_next     = '0;
                        state_next = S_ACC_RD;
                    end
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_RUN_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = ROW_W'(p_reg >> COL_W);
                state_next = S_RUN;
            end
            S_RUN:
            begin
                run_next = p_used ? 10'd0 : run_inc;
                priority if (!p_used && run_inc >= 10'(w_reg))
                begin
                    status_next = 1'b0;
                    found_next  = aa2d_pkg::POS_W'(p_reg);
                    base_next   = EW'(p_reg);
                    h_next      = 8'd1;
                    i_next      = '0;
                    set_next    = 1'b1;
                    state_next  = S_MK_INIT;
                end
                else if (p_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next = p_reg - 1'b1;
                    if (p_col == '0)
                    begin
                        state_next = S_RUN_RD;
                    end
                end
            end
            S_MK_INIT:
            begin
                if (w_reg == '0 || i_reg == 9'(h_reg) || (base_reg >> COL_W) >= EW'(ROWS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cr_next    = base_reg >> COL_W;
                    state_next = S_MK_RD;
                end
            end
            S_MK_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = ROW_W'(cr_reg);
                state_next = S_MK_WR;
            end
            S_MK_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = ROW_W'(cr_reg);
                mem_wdata = set_reg ? (rdata_reg | mk_mask) : (rdata_reg & ~mk_mask);
                if (mk_last)
                begin
                    base_next  = base_reg + EW'(ROW_SLOTS);
                    i_next     = i_reg + 9'd1;
                    state_next = S_MK_INIT;
                end
                else
                begin
                    cr_next    = cr_reg + EW'(1);
                    state_next = S_MK_RD;
                end
            end
            S_DONE:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            band_reg      <= aa2d_pkg::BAND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                band_reg <= band_slots_log2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        h_reg      <= h_next;
        amask_reg  <= amask_next;
        offb_reg   <= offb_next;
        r_reg      <= r_next;
        i_reg      <= i_next;
        acc_reg    <= acc_next;
        c_reg      <= c_next;
        p_reg      <= p_next;
        run_reg    <= run_next;
        base_reg   <= base_next;
        cr_reg     <= cr_next;
        set_reg    <= set_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // a waiting result closes the input so the result registers stay put
    assign in_ready       = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;

endmodule

// ----- sv/aa2d_checker.sv -----
// port-level checks of the 2d area allocator, bound to the top level
// depends on aa2d_pkg and area_allocator_2d_bitmap
module aa2d_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [aa2d_pkg::MODE_W-1:0]   mode,
    input logic [aa2d_pkg::WIDTH_W-1:0]  width,
    input logic [aa2d_pkg::HEIGHT_W-1:0] height,
    input logic [aa2d_pkg::AMASK_W-1:0]  align_mask,
    input logic [aa2d_pkg::OFFB_W-1:0]   offset_bytes,
    input logic [aa2d_pkg::POS_W-1:0]    position,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          status,
    input logic [aa2d_pkg::POS_W-1:0]    found_position,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [aa2d_pkg::BAND_W-1:0]   band_slots_log2
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_position))
        else $error("result changed while stalled");

    // a failed request reports position zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> found_position == '0)
        else $error("failed result with nonzero position");

    // one request in flight: busy right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a waiting result keeps the input closed
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request input open while a result waits");

endmodule

bind area_allocator_2d_bitmap aa2d_port_checks u_aa2d_port_checks (.*);
